// ===== rtl/drdt_pkg.sv =====
// ----------------------------------------------------------------------------
// drdt_pkg
// Shared types, constants and helpers of the detection row decoder.
// ----------------------------------------------------------------------------
package drdt_pkg;

	// Box fields ahead of the class scores in every row
	localparam int unsigned BOX_FIELDS  = 5;
	localparam int unsigned MAX_CLASSES = 255;
	localparam int unsigned MAX_IMAGE   = 8192;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned CORNER_W = 29;
	localparam int unsigned CLASS_W  = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned SIZE_W   = 14;
	localparam int unsigned OUT_W    = 160;

	// Row positions of the box fields
	localparam logic [POS_W-1:0] POS_CENTER_X   = 9'd0;
	localparam logic [POS_W-1:0] POS_CENTER_Y   = 9'd1;
	localparam logic [POS_W-1:0] POS_BOX_WIDTH  = 9'd2;
	localparam logic [POS_W-1:0] POS_BOX_HEIGHT = 9'd3;
	localparam logic [POS_W-1:0] POS_OBJECTNESS = 9'd4;
	localparam logic [POS_W-1:0] POS_LAST       = POS_W'(BOX_FIELDS + MAX_CLASSES - 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SCORE_THRESHOLD = 2'd0,
		REG_CLASS_COUNT     = 2'd1,
		REG_IMAGE_WIDTH     = 2'd2,
		REG_IMAGE_HEIGHT    = 2'd3
	} reg_index_t;

	// Row geometry settings seen by the row tracker
	typedef struct packed {
		logic [CLASS_W-1:0] class_count;
		logic [SIZE_W-1:0]  image_width;
		logic [SIZE_W-1:0]  image_height;
	} row_cfg_t;

	// Finished row handed from the tracker to the scoring pipeline
	typedef struct packed {
		logic [CORNER_W-1:0]       left;
		logic [CORNER_W-1:0]       top;
		logic [CORNER_W-1:0]       right;
		logic [CORNER_W-1:0]       bottom;
		logic signed [VALUE_W-1:0] objectness;
		logic signed [VALUE_W-1:0] best_score;
		logic [CLASS_W-1:0]        best_class;
	} row_result_t;

	// Largest corner for an image size, (size - 1) << 16 after limiting size
	function automatic logic [CORNER_W-1:0] size_hi(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] lim;
		logic [SIZE_W-1:0] m1;
		lim = size;
		if (size == '0) begin
			lim = SIZE_W'(1);
		end else if (size > SIZE_W'(MAX_IMAGE)) begin
			lim = SIZE_W'(MAX_IMAGE);
		end
		m1 = lim - SIZE_W'(1);
		return {m1[12:0], 16'h0000};
	endfunction

	// Clip a 33-bit signed corner into [0, hi]
	function automatic logic [CORNER_W-1:0] clip_corner(input logic signed [32:0] v,
			input logic [CORNER_W-1:0] hi);
		logic [CORNER_W-1:0] r;
		r = v[CORNER_W-1:0];
		if (v < 33'sd0) begin
			r = '0;
		end else if (v > $signed({4'b0000, hi})) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ===== rtl/drdt_row_tracker.sv =====
// ----------------------------------------------------------------------------
// drdt_row_tracker
// Row state: box fields, running argmax, and clipped corners at row end.
// ----------------------------------------------------------------------------
module drdt_row_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic signed [drdt_pkg::VALUE_W-1:0]  value,
	input  drdt_pkg::row_cfg_t                   cfg,
	input  logic                                 drain,
	output logic                                 row_valid,
	output drdt_pkg::row_result_t                row_result
);

	logic [drdt_pkg::POS_W-1:0]          pos_q;
	logic signed [drdt_pkg::VALUE_W-1:0] center_x_q;
	logic signed [drdt_pkg::VALUE_W-1:0] center_y_q;
	logic signed [drdt_pkg::VALUE_W-1:0] box_width_q;
	logic signed [drdt_pkg::VALUE_W-1:0] box_height_q;
	logic signed [drdt_pkg::VALUE_W-1:0] objectness_q;
	logic signed [drdt_pkg::VALUE_W-1:0] best_q;
	logic [drdt_pkg::CLASS_W-1:0]        best_class_q;

	logic [drdt_pkg::POS_W-1:0]          cls;
	logic [drdt_pkg::CLASS_W-1:0]        count_eff;
	logic                                in_box;
	logic                                class_last;
	logic                                win;
	logic signed [drdt_pkg::VALUE_W-1:0] new_best;
	logic [drdt_pkg::CLASS_W-1:0]        new_class;
	logic signed [32:0]                  half_w;
	logic signed [32:0]                  half_h;
	logic signed [32:0]                  cx;
	logic signed [32:0]                  cy;
	logic [drdt_pkg::CORNER_W-1:0]       hi_x;
	logic [drdt_pkg::CORNER_W-1:0]       hi_y;

	// Class index, effective count and end-of-row test
	always_comb begin
		cls       = pos_q - drdt_pkg::POS_W'(drdt_pkg::BOX_FIELDS);
		in_box    = pos_q < drdt_pkg::POS_W'(drdt_pkg::BOX_FIELDS);
		count_eff = cfg.class_count;
		if (cfg.class_count == '0) begin
			count_eff = drdt_pkg::CLASS_W'(1);
		end else if ({1'b0, cfg.class_count} > 9'(drdt_pkg::MAX_CLASSES)) begin
			count_eff = drdt_pkg::CLASS_W'(drdt_pkg::MAX_CLASSES);
		end
		class_last = ({1'b0, cls} + 10'd1) >= {2'b00, count_eff};
	end

	// Running argmax, first maximum wins
	always_comb begin
		win       = value > best_q;
		new_best  = win ? value : best_q;
		new_class = win ? cls[drdt_pkg::CLASS_W-1:0] : best_class_q;
	end

	// Corners from the held box, floor half sizes
	always_comb begin
		half_w = $signed({box_width_q[31], box_width_q}) >>> 1;
		half_h = $signed({box_height_q[31], box_height_q}) >>> 1;
		cx     = {center_x_q[31], center_x_q};
		cy     = {center_y_q[31], center_y_q};
		hi_x   = drdt_pkg::size_hi(cfg.image_width);
		hi_y   = drdt_pkg::size_hi(cfg.image_height);
	end

	// Row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			center_x_q   <= '0;
			center_y_q   <= '0;
			box_width_q  <= '0;
			box_height_q <= '0;
			objectness_q <= '0;
			best_q       <= {1'b1, 31'h0};
			best_class_q <= '0;
		end else if (accept) begin
			case (pos_q)
				drdt_pkg::POS_CENTER_X: begin
					center_x_q <= value;
					pos_q      <= drdt_pkg::POS_CENTER_Y;
				end
				drdt_pkg::POS_CENTER_Y: begin
					center_y_q <= value;
					pos_q      <= drdt_pkg::POS_BOX_WIDTH;
				end
				drdt_pkg::POS_BOX_WIDTH: begin
					box_width_q <= value;
					pos_q       <= drdt_pkg::POS_BOX_HEIGHT;
				end
				drdt_pkg::POS_BOX_HEIGHT: begin
					box_height_q <= value;
					pos_q        <= drdt_pkg::POS_OBJECTNESS;
				end
				drdt_pkg::POS_OBJECTNESS: begin
					objectness_q <= value;
					pos_q        <= drdt_pkg::POS_W'(drdt_pkg::BOX_FIELDS);
				end
				default: begin
					if (class_last) begin
						pos_q        <= '0;
						best_q       <= {1'b1, 31'h0};
						best_class_q <= '0;
					end else begin
						pos_q        <= pos_q + drdt_pkg::POS_W'(1);
						best_q       <= new_best;
						best_class_q <= new_class;
					end
				end
			endcase
		end
	end

	// Finished row register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid <= 1'b0;
		end else if (accept && !in_box && class_last) begin
			row_valid <= 1'b1;
		end else if (drain) begin
			row_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_box && class_last) begin
			row_result.left       <= drdt_pkg::clip_corner(cx - half_w, hi_x);
			row_result.top        <= drdt_pkg::clip_corner(cy - half_h, hi_y);
			row_result.right      <= drdt_pkg::clip_corner(cx + half_w, hi_x);
			row_result.bottom     <= drdt_pkg::clip_corner(cy + half_h, hi_y);
			row_result.objectness <= objectness_q;
			row_result.best_score <= new_best;
			row_result.best_class <= new_class;
		end
	end

	// Checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= drdt_pkg::POS_LAST)
		else $error("row position beyond last class");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_box && class_last |=> pos_q == '0 && best_q == {1'b1, 31'h0})
		else $error("row state not cleared at row end");

	a_row_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(row_valid) |-> $past(accept))
		else $error("finished row without an accepted item");

endmodule

// ===== rtl/detection_row_decode_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// detection_row_decode_threshold_unit
// Decodes detector rows into clipped boxes and keeps those above threshold.
// ----------------------------------------------------------------------------
// Takes one Q15.16 value per cycle: per row, center x, center y, width, height,
// objectness, then class_count class scores. A row's box passes the finished-row,
// product and output registers to m_tdata if objectness times the best class
// score reaches score_threshold; otherwise the row yields nothing. The sustained
// rate is one input value per clock while the output does not stall, set by the
// single argmax compare at the input and the registered 32x32 multiplier in the
// middle stage. Two finished rows can queue behind a result that is not yet
// taken, and items inside a row keep flowing until those stages are full.
module detection_row_decode_threshold_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // [31:0] value
	// Output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [drdt_pkg::OUT_W-1:0]     m_tdata,   // [28:0] left, [57:29] top,
	                                                  // [86:58] right, [115:87] bottom,
	                                                  // [147:116] confidence,
	                                                  // [155:148] class_id, rest zero
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data
);

	logic signed [31:0]    threshold_q;
	drdt_pkg::row_cfg_t    row_cfg_q;

	logic                  rdy1;
	logic                  rdy2;
	logic                  rdy3;
	logic                  accept;

	logic                  v1;
	drdt_pkg::row_result_t row_s1;

	logic                  v2;
	logic signed [63:0]    prod_s2;
	logic [drdt_pkg::CORNER_W-1:0] left_s2;
	logic [drdt_pkg::CORNER_W-1:0] top_s2;
	logic [drdt_pkg::CORNER_W-1:0] right_s2;
	logic [drdt_pkg::CORNER_W-1:0] bottom_s2;
	logic [drdt_pkg::CLASS_W-1:0]  class_s2;

	logic                  v3;
	logic [drdt_pkg::CORNER_W-1:0] left_s3;
	logic [drdt_pkg::CORNER_W-1:0] top_s3;
	logic [drdt_pkg::CORNER_W-1:0] right_s3;
	logic [drdt_pkg::CORNER_W-1:0] bottom_s3;
	logic signed [31:0]    conf_s3;
	logic [drdt_pkg::CLASS_W-1:0]  class_s3;

	logic signed [31:0]    score;
	logic                  emit;
	logic                  fits;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q            <= 32'sd32768;
			row_cfg_q.class_count  <= 8'd80;
			row_cfg_q.image_width  <= 14'd416;
			row_cfg_q.image_height <= 14'd416;
		end else if (cfg_valid && cfg_ready) begin
			case (drdt_pkg::reg_index_t'(cfg_index))
				drdt_pkg::REG_SCORE_THRESHOLD: threshold_q <= cfg_data;
				drdt_pkg::REG_CLASS_COUNT:     row_cfg_q.class_count <= cfg_data[7:0];
				drdt_pkg::REG_IMAGE_WIDTH:     row_cfg_q.image_width <= cfg_data[13:0];
				drdt_pkg::REG_IMAGE_HEIGHT:    row_cfg_q.image_height <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Stage readiness, each stage moves when empty or draining
	assign rdy3     = !v3 || m_tready;
	assign rdy2     = !v2 || rdy3;
	assign rdy1     = !v1 || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && s_tready;

	// Row state and corner clipping
	drdt_row_tracker u_row (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.value      (s_tdata),
		.cfg        (row_cfg_q),
		.drain      (rdy2),
		.row_valid  (v1),
		.row_result (row_s1)
	);

	// Stage 2: score product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= 1'b0;
		end else if (rdy2) begin
			v2 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1) begin
			prod_s2   <= row_s1.objectness * row_s1.best_score;
			left_s2   <= row_s1.left;
			top_s2    <= row_s1.top;
			right_s2  <= row_s1.right;
			bottom_s2 <= row_s1.bottom;
			class_s2  <= row_s1.best_class;
		end
	end

	// Floor by 2^16, saturate, threshold
	always_comb begin
		fits = (prod_s2[63:47] == '0) || (prod_s2[63:47] == '1);
		if (fits) begin
			score = prod_s2[47:16];
		end else if (prod_s2[63]) begin
			score = {1'b1, 31'h0000_0000};
		end else begin
			score = {1'b0, 31'h7FFF_FFFF};
		end
		emit = score >= threshold_q;
	end

	// Stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3 <= 1'b0;
		end else if (rdy3) begin
			v3 <= v2 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2) begin
			left_s3   <= left_s2;
			top_s3    <= top_s2;
			right_s3  <= right_s2;
			bottom_s3 <= bottom_s2;
			conf_s3   <= score;
			class_s3  <= class_s2;
		end
	end

	assign m_tvalid = v3;
	assign m_tdata  = {4'h0, class_s3, conf_s3, bottom_s3, right_s3, top_s3, left_s3};

	// Checks
	a_emit_above_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> conf_s3 >= threshold_q)
		else $error("box below threshold emitted");

	a_x_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> left_s3 <= drdt_pkg::size_hi(row_cfg_q.image_width) &&
			right_s3 <= drdt_pkg::size_hi(row_cfg_q.image_width))
		else $error("x corner outside image");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2 && !rdy3 |=> v2 && $stable(prod_s2))
		else $error("product stage lost while stalled");

endmodule
